// File: sv/grwi_pkg.sv
// Package for the grid ray wall intersection block: types, codes and constants.
`default_nettype none
package grwi_pkg;

	localparam int GRID_SIDE  = 64;
	localparam int CELL_BITS  = 6;
	localparam int MAP_CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int MAP_AW     = 2 * CELL_BITS;
	localparam int COORD_W    = 14;
	localparam int FRAC_BITS  = 8;
	localparam int ANGLE_BITS = 12;
	localparam int WF         = 24;   // internal fraction bits
	localparam int POS_W      = 48;   // internal signed position width
	localparam int CORD_W     = 34;   // rotation datapath width
	localparam int CORD_STEPS = 30;
	localparam int DIV_STEPS  = 56;
	localparam int DIV_W      = 31;   // divisor width
	localparam int TAN_W      = 39;   // tangent width, limit 2^38
	localparam int WALK_MAX   = GRID_SIDE + 3;
	localparam int OUT_W      = 16;

	localparam logic [TAN_W-1:0] TAN_MAX = TAN_W'(1) << (TAN_W - 1);

	// rotation angles, full turn = 2^32
	localparam logic [29:0] ATAN_TAB [CORD_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

	typedef struct packed {
		logic                  kind;
		logic [CELL_BITS-1:0]  cell_x;
		logic [CELL_BITS-1:0]  cell_y;
		logic                  cell_wall;
		logic [COORD_W-1:0]    origin_x;
		logic [COORD_W-1:0]    origin_y;
		logic [ANGLE_BITS-1:0] heading;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] hit_x;
		logic signed [OUT_W-1:0] hit_y;
		logic                    hit_wall;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_MEMWR, ST_CINIT, ST_CSTEP, ST_DINIT,
		ST_DSTEP, ST_STEPS, ST_MUL0, ST_MUL1, ST_START, ST_PROBE, ST_CHECK,
		ST_SQX, ST_SQY, ST_SUM, ST_FINISH
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLEAR, OP_LOAD, OP_MEMWR, OP_CINIT, OP_CSTEP, OP_DINIT,
		OP_DSTEP, OP_STEPS, OP_MUL0, OP_MUL1, OP_START, OP_PROBE, OP_CHECK,
		OP_SQX, OP_SQY, OP_SUM, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel;   // 0 vertical-line walk, 1 horizontal-line walk
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic cordic_last;
		logic div_last;
		logic walk_done;
		logic axis;
		logic cast;
		logic quad_odd;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/grwi_ctrl.sv
// Controller state machine of the grid ray wall intersection block.
`default_nettype none
module grwi_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output grwi_pkg::dp_cmd_t       dcmd,
	input  wire grwi_pkg::dp_stat_t dstat
);

	grwi_pkg::ctrl_state_t state_q, state_d;
	logic sel_q;
	logic res_valid_q;
	logic out_free;
	logic accept;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != grwi_pkg::ST_IDLE);
	assign accept    = cmd_valid && (state_q == grwi_pkg::ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grwi_pkg::ST_CLEAR:  if (dstat.clr_last) state_d = grwi_pkg::ST_IDLE;
			grwi_pkg::ST_IDLE:   if (accept) state_d = grwi_pkg::ST_DECODE;
			grwi_pkg::ST_DECODE: begin
				if (!dstat.cast)
					state_d = grwi_pkg::ST_MEMWR;
				else if (dstat.axis)
					state_d = grwi_pkg::ST_STEPS;
				else
					state_d = grwi_pkg::ST_CINIT;
			end
			grwi_pkg::ST_MEMWR:  state_d = grwi_pkg::ST_FINISH;
			grwi_pkg::ST_CINIT:  state_d = grwi_pkg::ST_CSTEP;
			grwi_pkg::ST_CSTEP:  if (dstat.cordic_last) state_d = grwi_pkg::ST_DINIT;
			grwi_pkg::ST_DINIT:  state_d = grwi_pkg::ST_DSTEP;
			grwi_pkg::ST_DSTEP:  if (dstat.div_last) state_d = grwi_pkg::ST_STEPS;
			grwi_pkg::ST_STEPS:  state_d = grwi_pkg::ST_MUL0;
			grwi_pkg::ST_MUL0:   state_d = grwi_pkg::ST_MUL1;
			grwi_pkg::ST_MUL1:   state_d = grwi_pkg::ST_START;
			grwi_pkg::ST_START:  state_d = grwi_pkg::ST_PROBE;
			grwi_pkg::ST_PROBE:  state_d = grwi_pkg::ST_CHECK;
			grwi_pkg::ST_CHECK: begin
				if (!dstat.walk_done)
					state_d = grwi_pkg::ST_PROBE;
				else if (dstat.axis)
					state_d = grwi_pkg::ST_FINISH;
				else
					state_d = grwi_pkg::ST_SQX;
			end
			grwi_pkg::ST_SQX:    state_d = grwi_pkg::ST_SQY;
			grwi_pkg::ST_SQY:    state_d = grwi_pkg::ST_SUM;
			grwi_pkg::ST_SUM:    state_d = sel_q ? grwi_pkg::ST_FINISH : grwi_pkg::ST_MUL0;
			grwi_pkg::ST_FINISH: if (out_free) state_d = grwi_pkg::ST_IDLE;
			default:             state_d = grwi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		dcmd.sel = sel_q;
		dcmd.op  = grwi_pkg::OP_NOP;
		unique case (state_q)
			grwi_pkg::ST_CLEAR:  dcmd.op = grwi_pkg::OP_CLEAR;
			grwi_pkg::ST_IDLE:   dcmd.op = accept ? grwi_pkg::OP_LOAD : grwi_pkg::OP_NOP;
			grwi_pkg::ST_DECODE: dcmd.op = grwi_pkg::OP_NOP;
			grwi_pkg::ST_MEMWR:  dcmd.op = grwi_pkg::OP_MEMWR;
			grwi_pkg::ST_CINIT:  dcmd.op = grwi_pkg::OP_CINIT;
			grwi_pkg::ST_CSTEP:  dcmd.op = grwi_pkg::OP_CSTEP;
			grwi_pkg::ST_DINIT:  dcmd.op = grwi_pkg::OP_DINIT;
			grwi_pkg::ST_DSTEP:  dcmd.op = grwi_pkg::OP_DSTEP;
			grwi_pkg::ST_STEPS:  dcmd.op = grwi_pkg::OP_STEPS;
			grwi_pkg::ST_MUL0:   dcmd.op = grwi_pkg::OP_MUL0;
			grwi_pkg::ST_MUL1:   dcmd.op = grwi_pkg::OP_MUL1;
			grwi_pkg::ST_START:  dcmd.op = grwi_pkg::OP_START;
			grwi_pkg::ST_PROBE:  dcmd.op = grwi_pkg::OP_PROBE;
			grwi_pkg::ST_CHECK:  dcmd.op = grwi_pkg::OP_CHECK;
			grwi_pkg::ST_SQX:    dcmd.op = grwi_pkg::OP_SQX;
			grwi_pkg::ST_SQY:    dcmd.op = grwi_pkg::OP_SQY;
			grwi_pkg::ST_SUM:    dcmd.op = grwi_pkg::OP_SUM;
			grwi_pkg::ST_FINISH: dcmd.op = out_free ? grwi_pkg::OP_OUT : grwi_pkg::OP_NOP;
			default:             dcmd.op = grwi_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grwi_pkg::ST_CLEAR;
			sel_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// axis rays walk only one family of lines
			if (state_q == grwi_pkg::ST_DECODE)
				sel_q <= dstat.axis & dstat.quad_odd;
			else if (state_q == grwi_pkg::ST_SUM)
				sel_q <= 1'b1;
			if (state_q == grwi_pkg::ST_FINISH && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: sv/grwi_datapath.sv
// Datapath of the grid ray wall intersection block: map memory, rotation, divide, walk.
`default_nettype none
module grwi_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire grwi_pkg::cmd_t    cmd,
	input  wire grwi_pkg::dp_cmd_t dcmd,
	output grwi_pkg::dp_stat_t     dstat,
	output grwi_pkg::res_t         res
);

	localparam int PW = grwi_pkg::POS_W;
	localparam int CW = grwi_pkg::CORD_W;
	localparam int TW = grwi_pkg::TAN_W;
	localparam int DW = grwi_pkg::DIV_W;
	localparam int NW = grwi_pkg::DIV_STEPS;
	localparam int WF = grwi_pkg::WF;
	localparam int CB = grwi_pkg::CELL_BITS;
	localparam int AW = grwi_pkg::MAP_AW;
	localparam int SHIFT_IN = WF - grwi_pkg::FRAC_BITS;
	localparam int SQ_SHIFT = WF - 16;
	localparam logic signed [PW-1:0] ONE_W = PW'(1) << WF;

	// map memory
	logic           map_mem [grwi_pkg::MAP_CELLS];
	logic [AW-1:0]  clr_q;
	logic           rd_q;

	// latched item
	logic           kind_q;
	logic [AW-1:0]  cell_q;
	logic           wall_q;
	logic [1:0]     quad_q;
	logic [grwi_pkg::ANGLE_BITS-3:0] ang_q;
	logic signed [PW-1:0] ox_q, oy_q;

	// rotation
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [4:0]           it_q;

	// two dividers running side by side
	logic [NW-1:0]  nt_q, nc_q, qt_q, qc_q;
	logic [DW:0]    rt_q, rc_q;
	logic [DW-1:0]  dt_q, dc_q;
	logic [5:0]     dcnt_q;

	logic [TW-1:0]  colstep_q, rowstep_q;
	logic [44:0]    plo_q;
	logic [43:0]    phi_q;

	// walk
	logic signed [PW-1:0] wx_q, wy_q, stx_q, sty_q;
	logic [6:0]           n_q;
	logic                 oor_q;

	logic signed [PW-1:0] rx_q [2];
	logic signed [PW-1:0] ry_q [2];
	logic                 rh_q [2];
	logic [61:0]          dist_q [2];
	logic [61:0]          sqx_q, sqy_q;
	grwi_pkg::res_t       res_q;

	// combinational
	logic signed [CW-1:0] xs, ys, at, ax, ay;
	logic [DW-1:0]        xpos, ypos;
	logic [DW:0]          rt2, rc2;
	logic                 ge_t, ge_c;
	logic [TW-1:0]        tg, ct, step;
	logic                 sx_pos, sy_pos, dpos;
	logic [WF-1:0]        f;
	logic [WF:0]          d;
	logic [63:0]          prod;
	logic signed [PW-1:0] off, stepw, basex, basey;
	logic signed [PW-1:0] nx, ny, dxs, dys;
	logic [30:0]          dxc, dyc;
	logic                 stop, limit, pick;

	function automatic logic [30:0] clamp_dist(input logic signed [PW-1:0] v);
		logic [PW-1:0] a;
		logic [PW-SQ_SHIFT-1:0] s;
		a = v[PW-1] ? PW'(-v) : PW'(v);
		s = a[PW-1:SQ_SHIFT];
		if (s > (PW-SQ_SHIFT)'(1 << 30))
			return 31'(1 << 30);
		return s[30:0];
	endfunction

	function automatic logic signed [grwi_pkg::OUT_W-1:0] to_out(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		logic signed [31:0]   r;
		t = v + (PW'(1) << (SHIFT_IN - 1));
		r = 32'(t >>> SHIFT_IN);
		if (r > 32'sd32767)
			return 16'sh7FFF;
		if (r < -32'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic [TW-1:0] tan_limit(input logic [NW-1:0] q);
		if (q > NW'(grwi_pkg::TAN_MAX))
			return grwi_pkg::TAN_MAX;
		return q[TW-1:0];
	endfunction

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = CW'(grwi_pkg::ATAN_TAB[it_q]);
	assign ax = cx_q[CW-1] ? -cx_q : cx_q;
	assign ay = cy_q[CW-1] ? -cy_q : cy_q;
	assign xpos = (ax[DW-1:0] == '0) ? DW'(1) : ax[DW-1:0];
	assign ypos = (ay[DW-1:0] == '0) ? DW'(1) : ay[DW-1:0];

	assign rt2  = {rt_q[DW-1:0], nt_q[NW-1]};
	assign rc2  = {rc_q[DW-1:0], nc_q[NW-1]};
	assign ge_t = rt2 >= {1'b0, dt_q};
	assign ge_c = rc2 >= {1'b0, dc_q};
	assign tg   = tan_limit(qt_q);
	assign ct   = tan_limit(qc_q);

	assign sx_pos = (quad_q == 2'd0) || (quad_q == 2'd3);
	assign sy_pos = quad_q[1];
	assign dpos   = dcmd.sel ? sy_pos : sx_pos;
	assign f      = dcmd.sel ? oy_q[WF-1:0] : ox_q[WF-1:0];
	assign d      = dpos ? ((WF+1)'(1) << WF) - {1'b0, f} : {1'b0, f};
	assign step   = dcmd.sel ? rowstep_q : colstep_q;
	assign prod   = 64'(plo_q) + (64'(phi_q) << 20);
	assign off    = signed'({8'b0, prod[63:WF]});
	assign stepw  = signed'(PW'(step));
	assign basex  = {ox_q[PW-1:WF], WF'(0)};
	assign basey  = {oy_q[PW-1:WF], WF'(0)};

	assign nx    = wx_q + stx_q;
	assign ny    = wy_q + sty_q;
	assign stop  = oor_q | rd_q;
	assign limit = (n_q == 7'(grwi_pkg::WALK_MAX - 1));

	assign dxs  = rx_q[dcmd.sel] - ox_q;
	assign dys  = ry_q[dcmd.sel] - oy_q;
	assign dxc  = clamp_dist(dxs);
	assign dyc  = clamp_dist(dys);
	assign pick = (ang_q == '0) ? quad_q[0] : !(dist_q[0] < dist_q[1]);

	assign dstat.clr_last    = (clr_q == '1);
	assign dstat.cordic_last = (it_q == 5'(grwi_pkg::CORD_STEPS - 1));
	assign dstat.div_last    = (dcnt_q == 6'(NW - 1));
	assign dstat.walk_done   = stop | limit;
	assign dstat.axis        = (ang_q == '0);
	assign dstat.cast        = kind_q;
	assign dstat.quad_odd    = quad_q[0];
	assign res               = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (dcmd.op == grwi_pkg::OP_CLEAR)
			clr_q <= clr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == grwi_pkg::OP_CLEAR)
			map_mem[clr_q] <= 1'b0;
		else if (dcmd.op == grwi_pkg::OP_MEMWR)
			map_mem[cell_q] <= wall_q;
		rd_q <= map_mem[{wy_q[WF+CB-1:WF], wx_q[WF+CB-1:WF]}];
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			grwi_pkg::OP_LOAD: begin
				kind_q <= cmd.kind;
				cell_q <= {cmd.cell_y, cmd.cell_x};
				wall_q <= cmd.cell_wall;
				quad_q <= cmd.heading[grwi_pkg::ANGLE_BITS-1 -: 2];
				ang_q  <= cmd.heading[grwi_pkg::ANGLE_BITS-3:0];
				ox_q   <= signed'(PW'(cmd.origin_x) << SHIFT_IN);
				oy_q   <= signed'(PW'(cmd.origin_y) << SHIFT_IN);
			end
			grwi_pkg::OP_CINIT: begin
				cx_q <= CW'(1) << 28;
				cy_q <= '0;
				cz_q <= signed'(CW'(ang_q) << (32 - grwi_pkg::ANGLE_BITS));
				it_q <= '0;
			end
			grwi_pkg::OP_CSTEP: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
				it_q <= it_q + 5'd1;
			end
			grwi_pkg::OP_DINIT: begin
				nt_q   <= NW'(ypos) << WF;
				nc_q   <= NW'(xpos) << WF;
				dt_q   <= xpos;
				dc_q   <= ypos;
				rt_q   <= '0;
				rc_q   <= '0;
				qt_q   <= '0;
				qc_q   <= '0;
				dcnt_q <= '0;
			end
			grwi_pkg::OP_DSTEP: begin
				rt_q   <= ge_t ? rt2 - {1'b0, dt_q} : rt2;
				rc_q   <= ge_c ? rc2 - {1'b0, dc_q} : rc2;
				qt_q   <= {qt_q[NW-2:0], ge_t};
				qc_q   <= {qc_q[NW-2:0], ge_c};
				nt_q   <= nt_q << 1;
				nc_q   <= nc_q << 1;
				dcnt_q <= dcnt_q + 6'd1;
			end
			grwi_pkg::OP_STEPS: begin
				if (ang_q == '0) begin
					colstep_q <= '0;
					rowstep_q <= '0;
				end else if (quad_q[0]) begin
					colstep_q <= ct;
					rowstep_q <= tg;
				end else begin
					colstep_q <= tg;
					rowstep_q <= ct;
				end
			end
			grwi_pkg::OP_MUL0: plo_q <= 45'(d) * 45'(step[19:0]);
			grwi_pkg::OP_MUL1: phi_q <= 44'(d) * 44'(step[TW-1:20]);
			grwi_pkg::OP_START: begin
				n_q <= '0;
				if (!dcmd.sel) begin
					wx_q  <= sx_pos ? basex + ONE_W : basex - PW'(1);
					wy_q  <= sy_pos ? oy_q + off : oy_q - off;
					stx_q <= sx_pos ? ONE_W : -ONE_W;
					sty_q <= sy_pos ? stepw : -stepw;
				end else begin
					wy_q  <= sy_pos ? basey + ONE_W : basey - PW'(1);
					wx_q  <= sx_pos ? ox_q + off : ox_q - off;
					stx_q <= sx_pos ? stepw : -stepw;
					sty_q <= sy_pos ? ONE_W : -ONE_W;
				end
			end
			grwi_pkg::OP_PROBE: begin
				oor_q <= wx_q[PW-1] | wy_q[PW-1] | (|wx_q[PW-2:WF+CB]) | (|wy_q[PW-2:WF+CB]);
			end
			grwi_pkg::OP_CHECK: begin
				if (stop) begin
					rx_q[dcmd.sel] <= wx_q;
					ry_q[dcmd.sel] <= wy_q;
					rh_q[dcmd.sel] <= !oor_q & rd_q;
				end else begin
					wx_q <= nx;
					wy_q <= ny;
					n_q  <= n_q + 7'd1;
					if (limit) begin
						rx_q[dcmd.sel] <= nx;
						ry_q[dcmd.sel] <= ny;
						rh_q[dcmd.sel] <= 1'b0;
					end
				end
			end
			grwi_pkg::OP_SQX: sqx_q <= 62'(dxc) * 62'(dxc);
			grwi_pkg::OP_SQY: sqy_q <= 62'(dyc) * 62'(dyc);
			grwi_pkg::OP_SUM: dist_q[dcmd.sel] <= sqx_q + sqy_q;
			grwi_pkg::OP_OUT: begin
				if (kind_q) begin
					res_q.hit_x    <= to_out(rx_q[pick]);
					res_q.hit_y    <= to_out(ry_q[pick]);
					res_q.hit_wall <= rh_q[pick];
				end else begin
					res_q <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/grid_ray_wall_intersection.sv
// Top level of the grid ray wall intersection block.
`default_nettype none
// A 64 x 64 map of wall bits, written one cell per map item, and a ray caster
// over it. After reset the map is swept clear, one cell per cycle; no item is
// taken during the sweep. A map write passes through decode, memory write and
// finish before its all-zero result goes out on the result channel. An
// axis-aligned cast walks one family of grid lines, with one map read and one
// check per line crossed (at most 67 crossings). Any other cast runs a 30-step
// rotation for the tangent, a 56-step pair of dividers for tangent and
// cotangent, then two walks (vertical lines, then horizontal lines), each with
// its own setup and distance squaring. The single map read port sets the walk
// rate. One item is in work at a time; the finished result sits in an output
// register so the next item can be taken while it waits.
module grid_ray_wall_intersection (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire grwi_pkg::cmd_t  cmd,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output grwi_pkg::res_t       res
);

	grwi_pkg::dp_cmd_t  dcmd;
	grwi_pkg::dp_stat_t dstat;

	// sequencing: clear sweep, item decode, rotation, divide, walks, pick
	grwi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dcmd      (dcmd),
		.dstat     (dstat)
	);

	// map memory and all arithmetic
	grwi_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.dcmd   (dcmd),
		.dstat  (dstat),
		.res    (res)
	);

endmodule
`default_nettype wire

// File: tb/grwi_checker.sv
// Checker for the grid ray caster: watches both channels, predicts results, compares.
`default_nettype none
module grwi_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire logic           cmd_stall,
	input  wire grwi_pkg::cmd_t cmd,
	input  wire logic           res_valid,
	input  wire logic           res_stall,
	input  wire grwi_pkg::res_t res,
	output int                  fails,
	output int                  pending,
	output int                  casts,
	output int                  wall_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WF         = grwi_pkg::WF;
	localparam int GRID_SIDE  = grwi_pkg::GRID_SIDE;
	localparam int WALK_MAX   = grwi_pkg::WALK_MAX;
	localparam int CORD_STEPS = grwi_pkg::CORD_STEPS;
	localparam int ANGLE_BITS = grwi_pkg::ANGLE_BITS;
	localparam int FRAC_BITS  = grwi_pkg::FRAC_BITS;
	localparam int OUT_W      = grwi_pkg::OUT_W;
	localparam longint CELL_ONE = longint'(1) << WF;

	logic            wall_map [grwi_pkg::MAP_CELLS];
	grwi_pkg::res_t  expected_hits [$];

	initial begin
		fails = 0;
		casts = 0;
		wall_hits = 0;
	end

	assign pending = expected_hits.size();

	// 0 open, 1 wall, 2 off the map
	function automatic int cell_at(longint x, longint y);
		longint cx, cy;
		if (x < 0 || y < 0)
			return 2;
		cx = x >>> WF;
		cy = y >>> WF;
		if (cx >= GRID_SIDE || cy >= GRID_SIDE)
			return 2;
		return wall_map[cy * GRID_SIDE + cx] ? 1 : 0;
	endfunction

	function automatic bit step_line(longint x, longint y, longint sx, longint sy,
			output longint px, output longint py);
		int p;
		for (int n = 0; n < WALK_MAX; n++) begin
			p = cell_at(x, y);
			if (p != 0) begin
				px = x;
				py = y;
				return p == 1;
			end
			x += sx;
			y += sy;
		end
		px = x;
		py = y;
		return 0;
	endfunction

	function automatic longint scaled_off(longint d, longint slope);
		longint unsigned prod;
		prod = unsigned'(d) * unsigned'(slope);
		return longint'(prod >> WF);
	endfunction

	// vertical grid lines; one cell in x moves ys in y
	function automatic bit walk_columns(longint ox, longint oy, int dir, longint ys, int ydir,
			output longint px, output longint py);
		longint f, x0, d, off;
		f = ox & (CELL_ONE - 1);
		if (dir > 0) begin
			x0 = ox - f + CELL_ONE;
			d = CELL_ONE - f;
		end else begin
			x0 = ox - f - 1;   // nudge into the cell being entered
			d = f;
		end
		off = scaled_off(d, ys);
		return step_line(x0, ydir > 0 ? oy + off : oy - off,
			dir > 0 ? CELL_ONE : -CELL_ONE, ydir > 0 ? ys : -ys, px, py);
	endfunction

	function automatic bit walk_rows(longint ox, longint oy, int dir, longint xs, int xdir,
			output longint px, output longint py);
		longint f, y0, d, off;
		f = oy & (CELL_ONE - 1);
		if (dir > 0) begin
			y0 = oy - f + CELL_ONE;
			d = CELL_ONE - f;
		end else begin
			y0 = oy - f - 1;
			d = f;
		end
		off = scaled_off(d, xs);
		return step_line(xdir > 0 ? ox + off : ox - off, y0,
			xdir > 0 ? xs : -xs, dir > 0 ? CELL_ONE : -CELL_ONE, px, py);
	endfunction

	// rotation for tangent and cotangent within the quadrant
	function automatic void quadrant_slopes(int a, output longint tg, output longint ct);
		longint x, y, z, xs, ys;
		longint lim;
		lim = longint'(1) << 38;
		x = longint'(1) << 28;
		y = 0;
		z = longint'(a) << (32 - ANGLE_BITS);
		for (int i = 0; i < CORD_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(grwi_pkg::ATAN_TAB[i]);
			end else begin
				x += ys; y -= xs; z += longint'(grwi_pkg::ATAN_TAB[i]);
			end
		end
		if (x < 0) x = -x;
		if (y < 0) y = -y;
		if (x == 0) x = 1;
		if (y == 0) y = 1;
		tg = (y <<< WF) / x;
		ct = (x <<< WF) / y;
		if (tg > lim) tg = lim;
		if (ct > lim) ct = lim;
	endfunction

	function automatic longint unsigned span2(longint ox, longint oy, longint x, longint y);
		longint unsigned dx, dy, cap;
		cap = 64'd1 << 30;
		dx = longint'(x - ox < 0 ? ox - x : x - ox) >> (WF - 16);
		dy = longint'(y - oy < 0 ? oy - y : y - oy) >> (WF - 16);
		if (dx > cap) dx = cap;
		if (dy > cap) dy = cap;
		return dx * dx + dy * dy;
	endfunction

	function automatic logic signed [OUT_W-1:0] to_grid_units(longint v);
		longint r;
		r = (v + (longint'(1) << (WF - FRAC_BITS - 1))) >>> (WF - FRAC_BITS);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[OUT_W-1:0];
	endfunction

	function automatic grwi_pkg::res_t trace_ray(grwi_pkg::cmd_t c);
		grwi_pkg::res_t r;
		longint ox, oy, hx, hy, tg, ct, t, x1, y1, x2, y2;
		int     q, a, sx, sy;
		bit     hit, h1, h2;
		ox = longint'(c.origin_x) << (WF - FRAC_BITS);
		oy = longint'(c.origin_y) << (WF - FRAC_BITS);
		q = int'(c.heading) >> (ANGLE_BITS - 2);
		a = int'(c.heading) & ((1 << (ANGLE_BITS - 2)) - 1);
		if (a == 0) begin
			case (q)
				0: hit = walk_columns(ox, oy, 1, 0, 1, hx, hy);
				2: hit = walk_columns(ox, oy, -1, 0, 1, hx, hy);
				1: hit = walk_rows(ox, oy, -1, 0, 1, hx, hy);
				default: hit = walk_rows(ox, oy, 1, 0, 1, hx, hy);
			endcase
		end else begin
			sx = (q == 0 || q == 3) ? 1 : -1;
			sy = (q < 2) ? -1 : 1;
			quadrant_slopes(a, tg, ct);
			if (q[0]) begin
				t = tg; tg = ct; ct = t;
			end
			h1 = walk_columns(ox, oy, sx, tg, sy, x1, y1);
			h2 = walk_rows(ox, oy, sy, ct, sx, x2, y2);
			if (span2(ox, oy, x1, y1) < span2(ox, oy, x2, y2)) begin
				hx = x1; hy = y1; hit = h1;
			end else begin
				hx = x2; hy = y2; hit = h2;
			end
		end
		r.hit_x = to_grid_units(hx);
		r.hit_y = to_grid_units(hy);
		r.hit_wall = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grwi_pkg::res_t want;
		if (!arst_n) begin
			foreach (wall_map[i]) wall_map[i] = 1'b0;
			expected_hits.delete();
		end else begin
			if (cmd_valid && !cmd_stall) begin
				if (!cmd.kind) begin
					wall_map[{cmd.cell_y, cmd.cell_x}] = cmd.cell_wall;
					expected_hits.push_back('0);
				end else begin
					want = trace_ray(cmd);
					casts++;
					if (want.hit_wall) wall_hits++;
					expected_hits.push_back(want);
				end
			end
			if (res_valid && !res_stall) begin
				if (expected_hits.size() == 0) begin
					$error("result transfer with nothing expected");
					fails++;
				end else begin
					want = expected_hits.pop_front();
					if (res.hit_x !== want.hit_x) begin
						$error("hit_x: expected %0d, got %0d", want.hit_x, res.hit_x);
						fails++;
					end
					if (res.hit_y !== want.hit_y) begin
						$error("hit_y: expected %0d, got %0d", want.hit_y, res.hit_y);
						fails++;
					end
					if (res.hit_wall !== want.hit_wall) begin
						$error("hit_wall: expected %0d, got %0d", want.hit_wall, res.hit_wall);
						fails++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Top of the grid ray caster testbench: clock, reset, stimulus, watchdog and verdict.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transfer on either channel; covers the clear sweep of the map
	localparam int IDLE_LIMIT = 30000;
	localparam int RANDOM_ITEMS = 1330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	grwi_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	grwi_pkg::res_t res;

	int fails, pending, casts, wall_hits;
	int send_idle_pct = 0;   // sender gap odds, percent
	int recv_stall_pct = 0;  // receiver stall odds, percent
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	grid_ray_wall_intersection DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	grwi_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.fails(fails), .pending(pending), .casts(casts), .wall_hits(wall_hits)
	);

	// receiver back-pressure
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	// watchdog: ends a hung run
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one command transfer, with an optional gap before it
	task automatic issue(grwi_pkg::cmd_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic put_cell(int x, int y, bit wall);
		grwi_pkg::cmd_t c;
		logic [63:0]    noise;
		noise = {$urandom, $urandom};
		c = noise[$bits(grwi_pkg::cmd_t)-1:0];
		c.kind = 1'b0;
		c.cell_x = x[grwi_pkg::CELL_BITS-1:0];
		c.cell_y = y[grwi_pkg::CELL_BITS-1:0];
		c.cell_wall = wall;
		issue(c);
	endtask

	task automatic cast_ray(int ox, int oy, int ang);
		grwi_pkg::cmd_t c;
		logic [63:0]    noise;
		noise = {$urandom, $urandom};
		c = noise[$bits(grwi_pkg::cmd_t)-1:0];
		c.kind = 1'b1;
		c.origin_x = ox[grwi_pkg::COORD_W-1:0];
		c.origin_y = oy[grwi_pkg::COORD_W-1:0];
		c.heading = ang[grwi_pkg::ANGLE_BITS-1:0];
		issue(c);
	endtask

	// angles weighted toward axes and near-axis slopes
	function automatic int pick_angle();
		int r;
		r = $urandom_range(99);
		if (r < 15) return $urandom_range(3) * 1024;
		if (r < 25) return ($urandom_range(3) * 1024 + ($urandom_range(1) ? 1 : 1023)) & 12'hFFF;
		return $urandom_range(4095);
	endfunction

	initial begin
		int mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corner walls, each axis, diagonals, origin in a wall, map edges
		put_cell(0, 0, 1);
		put_cell(63, 63, 1);
		put_cell(32, 10, 1);
		put_cell(10, 32, 1);
		cast_ray(16'h0000, 16'h0000, 512);     // from the origin cell, up-right leaves
		cast_ray(14'h3FFF, 14'h3FFF, 0);       // far corner, +x leaves map
		cast_ray(14'h3FFF, 14'h3FFF, 2048);    // -x from far corner
		cast_ray(14'h3FFF, 14'h3FFF, 1024);    // up
		cast_ray(14'h0000, 14'h0000, 3072);    // down
		cast_ray(10 * 256 + 128, 10 * 256 + 128, 0);     // east into wall (32,10)
		cast_ray(10 * 256 + 128, 10 * 256 + 128, 3072);  // south into wall (10,32)
		cast_ray(32 * 256 + 77, 10 * 256 + 3, 1536);      // origin inside a wall
		cast_ray(5 * 256, 5 * 256, 2560);                 // exactly on grid lines
		cast_ray(1000, 9000, 1);
		cast_ray(1000, 9000, 1023);
		cast_ray(1000, 9000, 4095);
		cast_ray(1000, 9000, 3073);
		cast_ray(256, 256, 2560);              // down-left from (1,1), away from the wall at (0,0)
		put_cell(63, 63, 0);
		put_cell(0, 0, 0);
		cast_ray(14'h3FFF, 14'h3FFF, 512);

		// random: four phases of sender gaps and back-pressure, mostly a populated map
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = (i * 4) / RANDOM_ITEMS;
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			if ($urandom_range(99) < 35)
				put_cell($urandom_range(63), $urandom_range(63), $urandom_range(99) < 60);
			else
				cast_ray($urandom_range(16383), $urandom_range(16383), pick_angle());
		end
		cmd_valid <= 1'b0;
		recv_stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d casts (%0d ending on a wall) plus map writes,", casts, wall_hits);
		$display("over four idle and back-pressure phases");
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
